@@ src/ctd_pkg.sv @@
`default_nettype none

package ctd_pkg;

  // input word: one command byte of the stream
  typedef struct packed {
    logic [7:0] code_byte;
    logic       new_job;
  } in_word_t;

  // output word: one glyph or stop event
  typedef struct packed {
    logic               event_kind;
    logic [6:0]         glyph;
    logic [1:0]         font_number;
    logic [5:0]         size_points;
    logic signed [15:0] column_units;
    logic signed [23:0] row_units;
  } out_word_t;

  // decoder state carried from byte to byte
  typedef struct packed {
    logic [15:0] esc_sum;
    logic [15:0] col_acc;
    logic [23:0] row_acc;
    logic        backward_escape;
    logic        backward_lead;
    logic        upper_case;
    logic [1:0]  rail_mag_bits;
    logic        prev_big_size;
    logic [5:0]  cur_size;
    logic        seen_init;
    logic        stopped;
  } state_t;

  // size table entry: point size and the large-size flag of its code
  typedef struct packed {
    logic       big;
    logic [5:0] pts;
  } size_t;

  localparam logic [5:0] SizeReset = 6'd10;

  localparam state_t StateReset = '{
    esc_sum:         16'd0,
    col_acc:         16'd0,
    row_acc:         24'd0,
    backward_escape: 1'b0,
    backward_lead:   1'b0,
    upper_case:      1'b0,
    rail_mag_bits:   2'd0,
    prev_big_size:   1'b0,
    cur_size:        SizeReset,
    seen_init:       1'b0,
    stopped:         1'b0
  };

  localparam logic signed [12:0] StartRowReset = -13'sd108;

  // event kinds
  localparam logic EvGlyph = 1'b0;
  localparam logic EvStop  = 1'b1;

  // command codes
  localparam logic [7:0] CodeInit     = 8'o100;
  localparam logic [7:0] CodeRailLow  = 8'o101;
  localparam logic [7:0] CodeRailHigh = 8'o102;
  localparam logic [7:0] CodeMagHigh  = 8'o103;
  localparam logic [7:0] CodeMagLow   = 8'o104;
  localparam logic [7:0] CodeLower    = 8'o105;
  localparam logic [7:0] CodeUpper    = 8'o106;
  localparam logic [7:0] CodeEscFwd   = 8'o107;
  localparam logic [7:0] CodeEscBack  = 8'o110;
  localparam logic [7:0] CodeLeadFwd  = 8'o112;
  localparam logic [7:0] CodeLeadBack = 8'o114;

  // escape correction applied when crossing into or out of the large sizes
  localparam logic [15:0] EscCorr = 16'd55;

  // saturate a 17 bit two's complement sum to 16 bits
  function automatic logic [15:0] sat16(input logic [16:0] v);
    logic [15:0] r;
    if (v[16] != v[15]) begin
      r = v[16] ? 16'h8000 : 16'h7fff;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // saturate a 25 bit two's complement sum to 24 bits
  function automatic logic [23:0] sat24(input logic [24:0] v);
    logic [23:0] r;
    if (v[24] != v[23]) begin
      r = v[24] ? 24'h800000 : 24'h7fffff;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // size code low nibble to point size; the unused nibble gives size 0
  function automatic size_t size_lookup(input logic [3:0] nib);
    size_t r;
    unique case (nib)
      4'd0:    r = '{big: 1'b0, pts: 6'd7};
      4'd1:    r = '{big: 1'b0, pts: 6'd8};
      4'd2:    r = '{big: 1'b0, pts: 6'd10};
      4'd3:    r = '{big: 1'b0, pts: 6'd11};
      4'd4:    r = '{big: 1'b0, pts: 6'd12};
      4'd5:    r = '{big: 1'b0, pts: 6'd14};
      4'd6:    r = '{big: 1'b0, pts: 6'd18};
      4'd7:    r = '{big: 1'b0, pts: 6'd9};
      4'd8:    r = '{big: 1'b0, pts: 6'd6};
      4'd9:    r = '{big: 1'b1, pts: 6'd16};
      4'd10:   r = '{big: 1'b1, pts: 6'd20};
      4'd11:   r = '{big: 1'b1, pts: 6'd22};
      4'd12:   r = '{big: 1'b1, pts: 6'd24};
      4'd13:   r = '{big: 1'b1, pts: 6'd28};
      4'd14:   r = '{big: 1'b1, pts: 6'd36};
      default: r = '{big: 1'b0, pts: 6'd0};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/cat_typesetter_code_decoder.sv @@
// a word waits in the input register; its event waits in the output register
// throughput: one command byte per cycle unless the output stalls, set by the
// single state update pass between the input register and the output register
// reset: asynchronous active low; clears position, modes and handshake state,
// size to 10 points and start row to -108
`default_nettype none

module cat_typesetter_code_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic signed [12:0]   cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ctd_pkg::in_word_t    in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ctd_pkg::out_word_t   out_word_o
);
  import ctd_pkg::*;

  logic               in_valid_q, in_valid_d;
  in_word_t           in_word_q;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_word_q;
  state_t             state_q, state_d;
  logic signed [12:0] start_row_q;
  logic               accept;
  logic               advance;
  logic               step_emit;
  out_word_t          step_result;

  // handshake: the held word moves on once the output slot is free
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  // byte decode
  ctd_step u_step (
    .state_i     (state_q),
    .word_i      (in_word_q),
    .start_row_i (start_row_q),
    .state_o     (state_d),
    .emit_o      (step_emit),
    .result_o    (step_result)
  );

  // next valid flags
  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = step_emit;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
      start_row_q <= StartRowReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
      if (cfg_we_i) begin
        start_row_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_word_q <= in_word_i;
    end
    if (advance && step_emit) begin
      out_word_q <= step_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // a stop only follows an earlier initialisation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.stopped |-> state_q.seen_init)
    else $error("stopped without initialisation");

  // stall is only raised while a word is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("stall without held word");

  // an emitted event is presented next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && step_emit) |=> out_valid_q)
    else $error("event lost");

  // any event leaves no pending escape
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && step_emit) |=> (state_q.esc_sum == 16'd0))
    else $error("escape left pending after event");

  // stop events carry no glyph
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_word_q.event_kind == EvStop)) |-> (out_word_q.glyph == 7'd0))
    else $error("stop event with glyph");

endmodule

`default_nettype wire

@@ src/ctd_step.sv @@
`default_nettype none

module ctd_step (
  input  ctd_pkg::state_t         state_i,
  input  ctd_pkg::in_word_t       word_i,
  input  logic signed [12:0]      start_row_i,
  output ctd_pkg::state_t         state_o,
  output logic                    emit_o,
  output ctd_pkg::out_word_t      result_o
);
  import ctd_pkg::*;

  always_comb begin
    state_t      s;
    logic [7:0]  c;
    logic        stop_eff;
    logic [15:0] esc_neg;
    logic [15:0] esc_mov;
    logic [4:0]  lead5;
    logic [6:0]  lead3;
    logic [24:0] lead_mag;
    logic [24:0] lead_delta;
    size_t       sz;
    logic        corr_on;
    logic        corr_neg;

    s          = state_i;
    c          = word_i.code_byte;
    emit_o     = 1'b0;
    result_o   = '0;
    stop_eff   = state_i.stopped & ~word_i.new_job;
    s.stopped  = stop_eff;
    esc_neg    = sat16(17'd0 - {state_i.esc_sum[15], state_i.esc_sum});
    esc_mov    = state_i.backward_escape ? esc_neg : state_i.esc_sum;
    lead5      = ~c[4:0];
    lead3      = 7'({2'b00, lead5} + {1'b0, lead5, 1'b0});
    lead_mag   = {18'd0, lead3};
    lead_delta = state_i.backward_lead ? (25'd0 - lead_mag) : lead_mag;
    sz         = size_lookup(c[3:0]);
    corr_on    = state_i.prev_big_size ^ sz.big;
    corr_neg   = sz.big ^ state_i.backward_escape;

    if (stop_eff || (c == 8'd0)) begin
      // ignored byte
    end else if (c[7]) begin
      // escape: accumulate motion
      s.esc_sum = sat16({s.esc_sum[15], s.esc_sum} + {10'd0, ~c[6:0]});
    end else begin
      // pending escape moves the column first
      s.col_acc = sat16({s.col_acc[15], s.col_acc} + {esc_mov[15], esc_mov});
      s.esc_sum = 16'd0;

      if (c[6] == 1'b0) begin
        // character
        emit_o                = 1'b1;
        result_o.event_kind   = EvGlyph;
        result_o.glyph        = {s.upper_case, c[5:0]};
      end else if (c[5]) begin
        // leading
        s.row_acc = sat24({s.row_acc[23], s.row_acc} + lead_delta);
      end else if (c[4]) begin
        // size change with escape correction
        if (corr_on) begin
          s.esc_sum = corr_neg ? (16'd0 - EscCorr) : EscCorr;
        end
        s.prev_big_size = sz.big;
        s.cur_size      = sz.pts;
      end else begin
        unique case (c)
          CodeInit: begin
            if (s.seen_init) begin
              s.stopped           = 1'b1;
              emit_o              = 1'b1;
              result_o.event_kind = EvStop;
              result_o.glyph      = 7'd0;
            end else begin
              s.seen_init       = 1'b1;
              s.row_acc         = {{11{start_row_i[12]}}, start_row_i};
              s.col_acc         = 16'd0;
              s.backward_lead   = 1'b0;
              s.backward_escape = 1'b0;
              s.upper_case      = 1'b0;
              s.rail_mag_bits   = 2'd0;
            end
          end
          CodeRailLow:  s.rail_mag_bits[0] = 1'b0;
          CodeRailHigh: s.rail_mag_bits[0] = 1'b1;
          CodeMagHigh:  s.rail_mag_bits[1] = 1'b1;
          CodeMagLow:   s.rail_mag_bits[1] = 1'b0;
          CodeLower:    s.upper_case = 1'b0;
          CodeUpper:    s.upper_case = 1'b1;
          CodeEscFwd:   s.backward_escape = 1'b0;
          CodeEscBack:  s.backward_escape = 1'b1;
          CodeLeadFwd:  s.backward_lead = 1'b0;
          CodeLeadBack: s.backward_lead = 1'b1;
          default: ;
        endcase
      end
    end

    // events carry the state as it stands after the byte
    result_o.font_number  = s.rail_mag_bits;
    result_o.size_points  = s.cur_size;
    result_o.column_units = s.col_acc;
    result_o.row_units    = s.row_acc;
    state_o               = s;
  end

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`default_nettype none

module tb;
  import ctd_pkg::*;

  // byte classes of the command stream
  localparam logic [7:0] CodeNull        = 8'o000;
  localparam logic [7:0] CharFirst       = 8'o001;
  localparam logic [7:0] CharLast        = 8'o077;
  localparam logic [7:0] ModeLast        = 8'o117;
  localparam logic [7:0] SizeFirst       = 8'o120;
  localparam logic [7:0] SizeBigFirst    = 8'o131;
  localparam logic [7:0] SizeLast        = 8'o137;
  localparam logic [7:0] LeadFirst       = 8'o140;
  localparam logic [7:0] LeadLast        = 8'o177;
  localparam logic [7:0] EscFirst        = 8'o200;
  localparam logic [7:0] EscLast         = 8'o377;
  localparam logic [3:0] NibBigFirst     = 4'd9;
  localparam logic [3:0] NibBigLast      = 4'd14;
  localparam int         SizeCorrUnits   = 55;
  localparam int         LeadStep        = 3;
  localparam logic signed [12:0] RowMin  = -13'sd4096;
  localparam logic signed [12:0] RowMax  = 13'sd4095;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic signed [12:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_word_o;

  cat_typesetter_code_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // decoder state as the bench predicts it
  logic signed [15:0] esc_pending = '0;
  logic signed [15:0] column_pos = '0;
  logic signed [23:0] row_pos = '0;
  logic signed [12:0] start_row_reg = StartRowReset;
  logic               esc_backward = 1'b0;
  logic               lead_backward = 1'b0;
  logic               upper_shift = 1'b0;
  logic [1:0]         rail_mag = '0;
  logic               prev_big = 1'b0;
  logic [5:0]         point_size = SizeReset;
  logic               init_seen = 1'b0;
  logic               job_stopped = 1'b0;

  out_word_t expected_events[$];
  out_word_t next_event;
  int        mismatches = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  bit        last_ignored;

  function automatic logic signed [15:0] clamp16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [23:0] clamp24(input int v);
    if (v > 8388607) return 24'sh7fffff;
    if (v < -8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // point size selected by the low nibble of a size code
  function automatic logic [5:0] points_of(input logic [3:0] nib);
    case (nib)
      4'd0:    return 6'd7;
      4'd1:    return 6'd8;
      4'd2:    return 6'd10;
      4'd3:    return 6'd11;
      4'd4:    return 6'd12;
      4'd5:    return 6'd14;
      4'd6:    return 6'd18;
      4'd7:    return 6'd9;
      4'd8:    return 6'd6;
      4'd9:    return 6'd16;
      4'd10:   return 6'd20;
      4'd11:   return 6'd22;
      4'd12:   return 6'd24;
      4'd13:   return 6'd28;
      4'd14:   return 6'd36;
      default: return 6'd0;
    endcase
  endfunction

  function automatic out_word_t event_now(input logic kind, input logic [6:0] glyph);
    out_word_t ev;
    ev.event_kind   = kind;
    ev.glyph        = glyph;
    ev.font_number  = rail_mag;
    ev.size_points  = point_size;
    ev.column_units = column_pos;
    ev.row_units    = row_pos;
    return ev;
  endfunction

  // advance the predicted state by one byte; returns 1 when an event is due
  function automatic bit decode_byte(input logic [7:0] code, input logic new_job,
                                     output out_word_t ev, output bit ignored);
    logic signed [15:0] shift;
    int                 lead;
    int                 corr;
    bit                 big;
    ev = '0;
    ignored = 1'b0;
    if (new_job) job_stopped = 1'b0;
    if (job_stopped || code == CodeNull) begin
      ignored = 1'b1;
      return 1'b0;
    end
    // escape: add up horizontal motion
    if (code[7]) begin
      esc_pending = clamp16(int'(esc_pending) + int'(7'h7f ^ code[6:0]));
      return 1'b0;
    end
    // pending motion lands on the column before anything else
    if (esc_pending != 0) begin
      shift = esc_backward ? clamp16(-int'(esc_pending)) : esc_pending;
      column_pos = clamp16(int'(column_pos) + int'(shift));
      esc_pending = '0;
    end
    if (code <= CharLast) begin
      ev = event_now(EvGlyph, {upper_shift, code[5:0]});
      return 1'b1;
    end
    if (code >= LeadFirst) begin
      lead = int'(5'h1f ^ code[4:0]);
      if (lead_backward) lead = -lead;
      row_pos = clamp24(int'(row_pos) + lead * LeadStep);
      return 1'b0;
    end
    if (code >= SizeFirst) begin
      big = (code[3:0] >= NibBigFirst) && (code[3:0] <= NibBigLast);
      corr = 0;
      if (!prev_big && big) corr = -SizeCorrUnits;
      else if (prev_big && !big) corr = SizeCorrUnits;
      if (esc_backward) corr = -corr;
      esc_pending = clamp16(int'(esc_pending) + corr);
      prev_big = big;
      point_size = points_of(code[3:0]);
      return 1'b0;
    end
    case (code)
      CodeInit: begin
        if (init_seen) begin
          job_stopped = 1'b1;
          ev = event_now(EvStop, '0);
          return 1'b1;
        end
        init_seen = 1'b1;
        row_pos = {{11{start_row_reg[12]}}, start_row_reg};
        column_pos = '0;
        esc_pending = '0;
        lead_backward = 1'b0;
        esc_backward = 1'b0;
        upper_shift = 1'b0;
        rail_mag = '0;
      end
      CodeRailLow:  rail_mag[0] = 1'b0;
      CodeRailHigh: rail_mag[0] = 1'b1;
      CodeMagHigh:  rail_mag[1] = 1'b1;
      CodeMagLow:   rail_mag[1] = 1'b0;
      CodeLower:    upper_shift = 1'b0;
      CodeUpper:    upper_shift = 1'b1;
      CodeEscFwd:   esc_backward = 1'b0;
      CodeEscBack:  esc_backward = 1'b1;
      CodeLeadFwd:  lead_backward = 1'b0;
      CodeLeadBack: lead_backward = 1'b1;
      default: ;
    endcase
    return 1'b0;
  endfunction

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  function automatic void report_field(input string name, input logic signed [31:0] want,
                                       input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // compare each event word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual %h", $time, out_word_o);
        mismatches++;
      end else begin
        next_event = expected_events.pop_front();
        report_field("event_kind", next_event.event_kind, out_word_o.event_kind);
        report_field("glyph", next_event.glyph, out_word_o.glyph);
        report_field("font_number", next_event.font_number, out_word_o.font_number);
        report_field("size_points", next_event.size_points, out_word_o.size_points);
        report_field("column_units", next_event.column_units, out_word_o.column_units);
        report_field("row_units", next_event.row_units, out_word_o.row_units);
      end
    end
  end

  // offer one byte, hold it until taken, then predict its event
  task automatic send_byte(input logic [7:0] code, input logic new_job);
    in_word_t  w;
    out_word_t ev;
    bit        ign;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    w.code_byte = code;
    w.new_job   = new_job;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    if (decode_byte(code, new_job, ev, ign)) expected_events.push_back(ev);
    last_ignored = ign;
  endtask

  // let every predicted event drain and the pipeline settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_start_row(input logic signed [12:0] row);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= row;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    start_row_reg = row;
  endtask

  // mostly well-formed codes, with some stops, nulls and noise
  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 8'($urandom_range(CharLast, CharFirst));
    if (r < 58) return 8'($urandom_range(EscLast, EscFirst));
    if (r < 68) return 8'($urandom_range(ModeLast, CodeRailLow));
    if (r < 78) return 8'($urandom_range(SizeLast, SizeFirst));
    if (r < 88) return 8'($urandom_range(LeadLast, LeadFirst));
    if (r < 90) return CodeInit;
    if (r < 93) return CodeNull;
    return 8'($urandom_range(EscLast, CodeNull));
  endfunction

  // start row written several times before the one initialization uses it
  task automatic test_start_row();
    logic signed [12:0] pick;
    write_start_row(RowMax);
    write_start_row(RowMin);
    write_start_row('0);
    case ($urandom_range(2))
      0:       pick = RowMin;
      1:       pick = RowMax;
      default: pick = 13'($urandom);
    endcase
    write_start_row(pick);
    @(posedge clk_i);
  endtask

  // glyphs and escapes before any initialization
  task automatic test_reset_state();
    send_byte(CodeNull, 1'b1);
    send_byte(CharLast, 1'b0);
    send_byte(EscFirst, 1'b0);
    send_byte(EscLast, 1'b0);
    send_byte(CharFirst, 1'b0);
  endtask

  // initialization, then every mode code including the undefined ones
  task automatic test_mode_codes();
    send_byte(CodeInit, 1'b0);
    for (int c = CodeRailLow; c <= ModeLast; c++) begin
      send_byte(8'(c), 1'b0);
      if (c == CodeRailHigh || c == CodeMagHigh || c == CodeUpper)
        send_byte(CharLast, 1'b0);
    end
  endtask

  // size correction both ways, unknown size, leading, stop and restart
  task automatic test_sizes_leads_stop();
    send_byte(EscFirst, 1'b0);
    send_byte(SizeBigFirst, 1'b0);
    send_byte(CharFirst, 1'b0);
    send_byte(SizeLast, 1'b0);
    send_byte(CharFirst, 1'b0);
    send_byte(LeadFirst, 1'b0);
    send_byte(LeadLast, 1'b0);
    send_byte(CharLast, 1'b0);
    send_byte(CodeInit, 1'b0);
    send_byte(CharLast, 1'b0);
    send_byte(CodeNull, 1'b1);
    send_byte(CharFirst, 1'b0);
    wait_idle();
  endtask

  // drive the escape sum into its upper rail and the column into both rails, leading both ways
  task automatic test_saturation();
    idle_pct  = 0;
    stall_pct = 0;
    send_byte(CodeEscFwd, 1'b1);
    send_byte(CodeLeadFwd, 1'b0);
    repeat (2) begin
      repeat (259) send_byte(EscFirst, 1'b0);
      send_byte(CharFirst, 1'b0);
    end
    send_byte(CodeEscBack, 1'b0);
    repeat (3) begin
      repeat (259) send_byte(EscFirst, 1'b0);
      send_byte(CharFirst, 1'b0);
    end
    repeat (4) send_byte(LeadFirst, 1'b0);
    send_byte(CharLast, 1'b0);
    send_byte(CodeLeadBack, 1'b0);
    repeat (8) send_byte(LeadFirst, 1'b0);
    send_byte(CharLast, 1'b0);
    wait_idle();
  endtask

  task automatic run_random_phase(input int words, input int sender_idle,
                                  input int recv_stall, input bit hold_off);
    int   taken;
    logic nj;
    idle_pct  = sender_idle;
    stall_pct = recv_stall;
    taken = 0;
    while (taken < words) begin
      nj = job_stopped ? ($urandom_range(9) < 4) : ($urandom_range(19) == 0);
      send_byte(pick_code(), nj);
      if (!last_ignored) begin
        taken++;
        // sender holds off until every event is out
        if (hold_off && taken == words / 2) wait_idle();
      end
    end
    wait_idle();
  endtask

  // random streams under each idling pattern, start row rewritten between
  task automatic test_random_stream();
    run_random_phase(150, 0, 0, 1'b0);
    write_start_row(RowMax);
    run_random_phase(150, 58, 0, 1'b1);
    write_start_row(RowMin);
    run_random_phase(150, 0, 58, 1'b0);
    write_start_row(13'($urandom));
    run_random_phase(150, 29, 29, 1'b0);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_start_row();
    test_reset_state();
    test_mode_codes();
    test_sizes_leads_stop();
    test_saturation();
    test_random_stream();
    idle_pct  = 0;
    stall_pct = 0;
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
